@@ rtl/nbbsr_pkg.sv @@
// Shared types, constants and codes of the NAND bad-block-skipping read sequencer.
// No dependencies; imported by every module in rtl.
package nbbsr_pkg;

  localparam int PagesPerBlock = 64;
  localparam int CacheEntries  = 32;
  localparam int BlockCount    = 65536;

  localparam int PageW    = $clog2(PagesPerBlock);
  localparam int PageCntW = PageW + 1;
  localparam int BlockW   = $clog2(BlockCount) + 1;
  localparam int CacheIdxW = (CacheEntries > 1) ? $clog2(CacheEntries) : 1;
  localparam int LbaW     = 24;
  localparam int SkipW    = LbaW - PageW;
  localparam int CountW   = 32;
  localparam int LeftW    = 22;
  localparam int ShiftMin = 11;
  localparam int ShiftMax = 12;

  localparam logic [7:0] MarkerGood = 8'hff;

  typedef enum logic [1:0] {
    OP_START = 2'd0,
    OP_SPARE = 2'd1,
    OP_READ  = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    KIND_SPARE   = 2'd0,
    KIND_READ    = 2'd1,
    KIND_DONE    = 2'd2,
    KIND_IGNORED = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE       = 2'd0,
    PH_WAIT_SPARE = 2'd1,
    PH_WAIT_READ  = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    SQ_READY  = 3'd0,
    SQ_WALK   = 3'd1,
    SQ_ISSUE  = 3'd2,
    SQ_FINISH = 3'd3,
    SQ_EMIT   = 3'd4
  } seq_e;

  typedef enum logic [1:0] {
    BS_UNKNOWN = 2'd0,
    BS_GOOD    = 2'd1,
    BS_BAD     = 2'd2
  } bstat_e;

  typedef enum logic {
    CFG_PAGE_SHIFT = 1'b0,
    CFG_PART_START = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    kind_e               kind;
    logic [15:0]         block;
    logic [PageW-1:0]    first_page;
    logic [PageCntW-1:0] page_count;
    logic [31:0]         bytes_done;
    logic                ran_off_end;
  } result_t;

endpackage

@@ rtl/nbbsr_status_cache.sv @@
// Bad-block status cache for the first blocks of the device: unknown, good or bad.
// Depends on nbbsr_pkg.
module nbbsr_status_cache import nbbsr_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [BlockW-1:0] block_i,
  input  logic              wr_en_i,
  input  logic              wr_bad_i,
  output bstat_e            status_o
);

  bstat_e entries_q [CacheEntries];
  logic   hit;

  assign hit = block_i < BlockW'(CacheEntries);

  // blocks beyond the cached range always read as unknown
  always_comb begin
    status_o = BS_UNKNOWN;
    if (hit) begin
      status_o = entries_q[block_i[CacheIdxW-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CacheEntries; i++) begin
        entries_q[i] <= BS_UNKNOWN;
      end
    end else if (wr_en_i && hit) begin
      entries_q[block_i[CacheIdxW-1:0]] <= wr_bad_i ? BS_BAD : BS_GOOD;
    end
  end

endmodule

@@ rtl/nbbsr_result_reg.sv @@
// Output register of the sequencer: holds one result until the consumer takes it.
// Depends on nbbsr_pkg.
module nbbsr_result_reg import nbbsr_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    load_i,
  input  result_t result_i,
  output logic    free_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t result_o
);

  logic    valid_q;
  result_t data_q;

  assign free_o      = !valid_q || !out_stall_i;
  assign out_valid_o = valid_q;
  assign result_o    = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (free_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      data_q <= result_i;
    end
  end

endmodule

@@ rtl/nand_bad_block_skip_reader.sv @@
// Top level of the NAND bad-block-skipping read sequencer.
// Depends on nbbsr_pkg, nbbsr_status_cache and nbbsr_result_reg.
//
// Each request (start, spare marker response, page read completion) gives exactly one
// result: a spare read command, a page read command, done, or ignored. After a request
// is taken, the walk sequencer spends one cycle per block and steps over the blocks whose
// status the cache already knows. It stops at the first block that needs a command, or at
// the end of the read. A spare read command goes from the walk straight to the emit step;
// a page read command or a done count is first formed in the issue or finish step. The
// result then moves through the emit step into the output register, and in_stall_o stays
// high from the taken request until then. The walk steps over at most the number of
// cached blocks, 32. A good spare response with nothing left to skip goes straight to the
// issue step, a failed page read straight to the finish step, and an ignored request
// straight to the emit step. Any wait for the output register lengthens the stall. A
// finished result waiting in the output register does not hold off the next request.
module nand_bad_block_skip_reader import nbbsr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [23:0] lba_i,
  input  logic [31:0] byte_count_i,
  input  logic [7:0]  marker_first_i,
  input  logic [7:0]  marker_second_i,
  input  logic        read_failed_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [15:0] block_o,
  output logic [5:0]  first_page_o,
  output logic [6:0]  page_count_o,
  output logic [31:0] bytes_done_o,
  output logic        ran_off_end_o
);

  logic [3:0]  shift_q;
  logic [15:0] part_q;

  seq_e                seq_q, seq_d;
  phase_e              phase_q, phase_d;
  logic [BlockW-1:0]   blk_q, blk_d;
  logic [SkipW-1:0]    skip_q, skip_d;
  logic [PageW-1:0]    off_q, off_d;
  logic [LeftW-1:0]    left_q, left_d;
  logic [LeftW-1:0]    read_q, read_d;
  logic [PageCntW-1:0] pend_q, pend_d;
  logic [CountW-1:0]   req_q, req_d;
  logic                fin_off_q, fin_off_d;
  result_t             res_q, res_d;

  logic                sh12;
  logic [CountW:0]     round_sum;
  logic [SkipW-1:0]    skip_blk;
  logic [SkipW-1:0]    part_ext;
  logic                spare_bad;
  logic [PageCntW-1:0] room;
  logic [PageCntW-1:0] run_pages;
  logic [CountW+1:0]   got;
  logic [CountW-1:0]   bytes;
  logic                cache_we;
  bstat_e              cache_st;
  logic                res_free;
  logic                res_load;
  result_t             res_out;
  op_e                 op;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= 4'(ShiftMax);
      part_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_PAGE_SHIFT: shift_q <= cfg_wdata_i[3:0];
        CFG_PART_START: part_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign sh12 = shift_q > 4'(ShiftMin);
  assign op   = op_e'(operation_i);

  assign round_sum = {1'b0, byte_count_i}
                   + (sh12 ? (CountW+1)'((1 << ShiftMax) - 1)
                           : (CountW+1)'((1 << ShiftMin) - 1));
  assign skip_blk  = lba_i[LbaW-1:PageW];
  assign part_ext  = SkipW'(part_q);
  assign spare_bad = read_failed_i || ((marker_first_i & marker_second_i) != MarkerGood);

  // run clipped to the end of the block
  assign room      = PageCntW'(PagesPerBlock) - {1'b0, off_q};
  assign run_pages = (left_q < LeftW'(room)) ? left_q[PageCntW-1:0] : room;

  assign got   = sh12 ? {read_q, {ShiftMax{1'b0}}} : {1'b0, read_q, {ShiftMin{1'b0}}};
  assign bytes = (got < {2'b00, req_q}) ? got[CountW-1:0] : req_q;

  assign in_stall_o = seq_q != SQ_READY;

  nbbsr_status_cache u_cache (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .block_i  (blk_q),
    .wr_en_i  (cache_we),
    .wr_bad_i (spare_bad),
    .status_o (cache_st)
  );

  always_comb begin
    seq_d     = seq_q;
    phase_d   = phase_q;
    blk_d     = blk_q;
    skip_d    = skip_q;
    off_d     = off_q;
    left_d    = left_q;
    read_d    = read_q;
    pend_d    = pend_q;
    req_d     = req_q;
    fin_off_d = fin_off_q;
    res_d     = res_q;
    cache_we  = 1'b0;
    res_load  = 1'b0;

    case (seq_q)
      SQ_READY: begin
        if (in_valid_i) begin
          res_d      = '0;
          res_d.kind = KIND_IGNORED;
          seq_d      = SQ_EMIT;
          case (op)
            OP_START: begin
              if (phase_q == PH_IDLE) begin
                req_d  = byte_count_i;
                left_d = sh12 ? {1'b0, round_sum[CountW:ShiftMax]}
                              : round_sum[CountW:ShiftMin];
                read_d = '0;
                pend_d = '0;
                off_d  = lba_i[PageW-1:0];
                blk_d  = BlockW'(part_q);
                skip_d = (skip_blk > part_ext) ? skip_blk - part_ext : '0;
                seq_d  = SQ_WALK;
              end
            end
            OP_SPARE: begin
              if (phase_q == PH_WAIT_SPARE) begin
                cache_we = 1'b1;
                phase_d  = PH_IDLE;
                if (skip_q != '0 || spare_bad) begin
                  if (skip_q != '0 && !spare_bad) begin
                    skip_d = skip_q - 1'b1;
                  end
                  blk_d = blk_q + 1'b1;
                  seq_d = SQ_WALK;
                end else begin
                  // good block with no skipping left: read from it directly
                  seq_d = SQ_ISSUE;
                end
              end
            end
            OP_READ: begin
              if (phase_q == PH_WAIT_READ) begin
                if (read_failed_i) begin
                  fin_off_d = 1'b0;
                  seq_d     = SQ_FINISH;
                end else begin
                  read_d  = read_q + LeftW'(pend_q);
                  left_d  = left_q - LeftW'(pend_q);
                  pend_d  = '0;
                  off_d   = '0;
                  blk_d   = blk_q + 1'b1;
                  phase_d = PH_IDLE;
                  seq_d   = SQ_WALK;
                end
              end
            end
            default: ;
          endcase
        end
      end
      SQ_WALK: begin
        if (skip_q == '0 && left_q == '0) begin
          fin_off_d = 1'b0;
          seq_d     = SQ_FINISH;
        end else if (blk_q >= BlockW'(BlockCount)) begin
          fin_off_d = 1'b1;
          seq_d     = SQ_FINISH;
        end else if (cache_st != BS_GOOD && cache_st != BS_BAD) begin
          phase_d          = PH_WAIT_SPARE;
          res_d            = '0;
          res_d.kind       = KIND_SPARE;
          res_d.block      = blk_q[15:0];
          res_d.page_count = PageCntW'(2);
          seq_d            = SQ_EMIT;
        end else if (skip_q != '0 || cache_st == BS_BAD) begin
          if (skip_q != '0 && cache_st != BS_BAD) begin
            skip_d = skip_q - 1'b1;
          end
          blk_d = blk_q + 1'b1;
        end else begin
          seq_d = SQ_ISSUE;
        end
      end
      SQ_ISSUE: begin
        pend_d           = run_pages;
        phase_d          = PH_WAIT_READ;
        res_d            = '0;
        res_d.kind       = KIND_READ;
        res_d.block      = blk_q[15:0];
        res_d.first_page = off_q;
        res_d.page_count = run_pages;
        seq_d            = SQ_EMIT;
      end
      SQ_FINISH: begin
        phase_d           = PH_IDLE;
        pend_d            = '0;
        res_d             = '0;
        res_d.kind        = KIND_DONE;
        res_d.bytes_done  = bytes;
        res_d.ran_off_end = fin_off_q;
        seq_d             = SQ_EMIT;
      end
      SQ_EMIT: begin
        if (res_free) begin
          res_load = 1'b1;
          seq_d    = SQ_READY;
        end
      end
      default: seq_d = SQ_READY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q   <= SQ_READY;
      phase_q <= PH_IDLE;
    end else begin
      seq_q   <= seq_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q     <= '0;
      skip_q    <= '0;
      off_q     <= '0;
      left_q    <= '0;
      read_q    <= '0;
      pend_q    <= '0;
      req_q     <= '0;
      fin_off_q <= 1'b0;
    end else begin
      blk_q     <= blk_d;
      skip_q    <= skip_d;
      off_q     <= off_d;
      left_q    <= left_d;
      read_q    <= read_d;
      pend_q    <= pend_d;
      req_q     <= req_d;
      fin_off_q <= fin_off_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  nbbsr_result_reg u_result (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (res_load),
    .result_i    (res_q),
    .free_o      (res_free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .result_o    (res_out)
  );

  assign kind_o        = res_out.kind;
  assign block_o       = res_out.block;
  assign first_page_o  = res_out.first_page;
  assign page_count_o  = res_out.page_count;
  assign bytes_done_o  = res_out.bytes_done;
  assign ran_off_end_o = res_out.ran_off_end;

  // a pending page run is never empty and never crosses the end of its block
  a_run_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_WAIT_READ) |->
      (pend_q != '0) && (({1'b0, pend_q} + PageCntW'(off_q)) <= (PageCntW+1)'(PagesPerBlock)))
    else $error("page run empty or past block end");

  // the walk moves at most one block per step
  a_walk_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_WALK) |=> (blk_q == $past(blk_q)) || (blk_q == $past(blk_q) + 1'b1))
    else $error("walk skipped more than one block");

  // a new result only appears from the emit step
  a_emit_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(seq_q == SQ_EMIT))
    else $error("result appeared outside emit");

  // the skip count only grows when a start request is taken
  a_skip_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skip_q > $past(skip_q)) |->
      $past(seq_q == SQ_READY && in_valid_i && op == OP_START && phase_q == PH_IDLE))
    else $error("skip count grew outside a start");

endmodule
